// ===== design/delta_timer_queue_top_assert.svh =====
// Assertion macros used by the checker file of the delta timer queue.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef DELTA_TIMER_QUEUE_TOP_ASSERT_SVH
`define DELTA_TIMER_QUEUE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DTQ_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("delta timer queue: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define DTQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("delta timer queue: next-cycle check failed");

`endif

// ===== design/dtq_pkg.sv =====
`default_nettype none

package dtq_pkg;

  localparam int unsigned DTQ_DEPTH = 32;

  localparam int unsigned DELAY_W = 16;
  localparam int unsigned MASK_W  = 16;
  localparam int unsigned ENTRY_W = DELAY_W + MASK_W;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  localparam logic [1:0] STAT_INSERTED = 2'd0;
  localparam logic [1:0] STAT_MERGED   = 2'd1;
  localparam logic [1:0] STAT_REJECTED = 2'd2;
  localparam logic [1:0] STAT_POPPED   = 2'd3;

endpackage

`default_nettype wire

// ===== design/dtq_ram.sv =====
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module dtq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== design/delta_timer_queue_top.sv =====
`default_nettype none

// Channel   Direction  Handshake               Payload
// in_       input      in_valid / in_ready     op, delay, task_mask, pop_count
// out_      output     out_valid / out_ready   status, head_delay, head_tasks, occupancy
//
// One transaction at a time; each RAM entry visited is read through the single read port.
// An insert of a zero delay is rejected; any other insert walks the list from the head, and a
// pop that leaves survivors copies each one forward.
// Reset (rst_n low, synchronous) empties the queue; the RAM keeps its contents, as entries
// at or past the count are never used. A finished result waits in the output register while
// the next transaction is taken; only a second finished result stalls on out_ready.
module delta_timer_queue_top
  import dtq_pkg::*;
#(
  parameter int unsigned DEPTH = DTQ_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_op,
  input  wire logic [15:0] in_delay,
  input  wire logic [15:0] in_task_mask,
  input  wire logic [5:0]  in_pop_count,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [15:0]      out_head_delay,
  output logic [15:0]      out_head_tasks,
  output logic [5:0]       out_occupancy
);

  // Address, count and comparison widths all follow from DEPTH.
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned NW = (CW > 6) ? CW : 6;

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_WALK   = 3'd1;
  localparam logic [2:0] S_APPEND = 3'd2;
  localparam logic [2:0] S_POP    = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] eidx_r, eidx_nxt;     // entry whose RAM data is on rd_data
  logic [CW-1:0] npop_r, npop_nxt;     // saturated pop count
  logic [16:0]   sum_r, sum_nxt;       // prefix sum of the entries before eidx_r
  logic          shift_r, shift_nxt;   // new entry placed, rippling the rest back
  logic [ENTRY_W-1:0] carry_r, carry_nxt;
  logic [15:0]   delay_r, delay_nxt;
  logic [15:0]   mask_r, mask_nxt;
  logic [1:0]    stat_r, stat_nxt;
  logic [15:0]   head_delta_r, head_mask_r;

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r;
  logic [15:0]   out_head_delay_r, out_head_tasks_r;
  logic [5:0]    out_occ_r;
  logic          out_load;

  // RAM port signals.
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic [AW-1:0]      rd_addr;
  logic [ENTRY_W-1:0] rd_data;

  // Each RAM word packs the delta in the upper half and the task mask below.
  dtq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_entry_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  logic [15:0]   ent_delta, ent_mask;
  logic [16:0]   sum_new, delay_ext;
  logic [16:0]   gap_before, gap_after, gap_tail;
  logic [CW-1:0] eidx_inc, count_dec, pop_dst;
  logic [NW-1:0] pop_ext, count_ext;
  logic [CW-1:0] pop_sat;
  logic          is_last, is_full;

  assign ent_delta  = rd_data[ENTRY_W-1:MASK_W];
  assign ent_mask   = rd_data[MASK_W-1:0];
  assign delay_ext  = {1'b0, delay_r};
  assign sum_new    = sum_r + {1'b0, ent_delta};
  // Deltas never wrap: the list sums to the largest delay it holds.
  assign gap_before = delay_ext - sum_r;
  assign gap_after  = sum_new - delay_ext;
  assign gap_tail   = delay_ext - sum_new;
  assign eidx_inc   = eidx_r + CW'(1);
  assign count_dec  = count_r - CW'(1);
  assign pop_dst    = eidx_r - npop_r;
  assign is_last    = (eidx_r == count_dec);
  assign is_full    = (count_r == CW'(DEPTH));
  assign pop_ext    = NW'(in_pop_count);
  assign count_ext  = NW'(count_r);
  assign pop_sat    = (pop_ext > count_ext) ? count_r : CW'(in_pop_count);

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    eidx_nxt  = eidx_r;
    npop_nxt  = npop_r;
    sum_nxt   = sum_r;
    shift_nxt = shift_r;
    carry_nxt = carry_r;
    delay_nxt = delay_r;
    mask_nxt  = mask_r;
    stat_nxt  = stat_r;
    wr_en     = 1'b0;
    wr_addr   = eidx_r[AW-1:0];
    wr_data   = rd_data;
    // By default the next entry is prefetched so one entry retires per cycle.
    rd_addr   = eidx_inc[AW-1:0];
    out_load  = 1'b0;

    case (state_r)
      S_IDLE: begin
        rd_addr = '0;
        if (in_valid) begin
          delay_nxt = in_delay;
          mask_nxt  = in_task_mask;
          if (in_op == OP_POP) begin
            stat_nxt = STAT_POPPED;
            npop_nxt = pop_sat;
            if (pop_sat == '0) begin
              state_nxt = S_DONE;
            end else if (pop_sat == count_r) begin
              count_nxt = '0;
              state_nxt = S_DONE;
            end else begin
              rd_addr   = pop_sat[AW-1:0];
              eidx_nxt  = pop_sat;
              state_nxt = S_POP;
            end
          end else if (in_delay == '0) begin
            stat_nxt  = STAT_REJECTED;
            state_nxt = S_DONE;
          end else if (count_r == '0) begin
            carry_nxt = {in_delay, in_task_mask};
            state_nxt = S_APPEND;
          end else begin
            eidx_nxt  = '0;
            sum_nxt   = '0;
            shift_nxt = 1'b0;
            state_nxt = S_WALK;
          end
        end
      end

      S_WALK: begin
        if (shift_r) begin
          // Ripple: each entry moves back one place behind the new one.
          wr_en     = 1'b1;
          wr_data   = carry_r;
          carry_nxt = rd_data;
          if (is_last) begin
            state_nxt = S_APPEND;
          end else begin
            eidx_nxt = eidx_inc;
          end
        end else if (delay_ext == sum_new) begin
          // Same expiry time as an existing entry: merge the task bits.
          wr_en     = 1'b1;
          wr_data   = {ent_delta, ent_mask | mask_r};
          stat_nxt  = STAT_MERGED;
          state_nxt = S_DONE;
        end else if (delay_ext < sum_new) begin
          if (is_full) begin
            stat_nxt  = STAT_REJECTED;
            state_nxt = S_DONE;
          end else begin
            // Place the new entry here; the displaced entry keeps its mask and
            // its delta shrinks by the new entry's share.
            wr_en     = 1'b1;
            wr_data   = {gap_before[15:0], mask_r};
            carry_nxt = {gap_after[15:0], ent_mask};
            shift_nxt = 1'b1;
            if (is_last) begin
              state_nxt = S_APPEND;
            end else begin
              eidx_nxt = eidx_inc;
            end
          end
        end else begin
          sum_nxt = sum_new;
          if (is_last) begin
            if (is_full) begin
              stat_nxt  = STAT_REJECTED;
              state_nxt = S_DONE;
            end else begin
              carry_nxt = {gap_tail[15:0], mask_r};
              state_nxt = S_APPEND;
            end
          end else begin
            eidx_nxt = eidx_inc;
          end
        end
      end

      S_APPEND: begin
        wr_en     = 1'b1;
        wr_addr   = count_r[AW-1:0];
        wr_data   = carry_r;
        count_nxt = count_r + CW'(1);
        stat_nxt  = STAT_INSERTED;
        state_nxt = S_DONE;
      end

      S_POP: begin
        // Copy each surviving entry forward by the pop count.
        wr_en   = 1'b1;
        wr_addr = pop_dst[AW-1:0];
        wr_data = rd_data;
        if (is_last) begin
          count_nxt = count_r - npop_r;
          state_nxt = S_DONE;
        end else begin
          eidx_nxt = eidx_inc;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = (out_valid_r && !out_ready) || out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers and the result payload need no reset.
  always_ff @(posedge clk) begin
    eidx_r  <= eidx_nxt;
    npop_r  <= npop_nxt;
    sum_r   <= sum_nxt;
    shift_r <= shift_nxt;
    carry_r <= carry_nxt;
    delay_r <= delay_nxt;
    mask_r  <= mask_nxt;
    stat_r  <= stat_nxt;
    // A shadow copy of entry 0 follows every write to it.
    if (wr_en && (wr_addr == '0)) begin
      head_delta_r <= wr_data[ENTRY_W-1:MASK_W];
      head_mask_r  <= wr_data[MASK_W-1:0];
    end
    if (out_load) begin
      out_status_r     <= stat_r;
      out_head_delay_r <= (count_r == '0) ? '0 : head_delta_r;
      out_head_tasks_r <= (count_r == '0) ? '0 : head_mask_r;
      out_occ_r        <= count_ext[5:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_head_delay = out_head_delay_r;
  assign out_head_tasks = out_head_tasks_r;
  assign out_occupancy  = out_occ_r;

endmodule

`default_nettype wire

// ===== design/dtq_checker.sv =====
`default_nettype none

`include "delta_timer_queue_top_assert.svh"

module dtq_checker
  import dtq_pkg::*;
#(
  parameter int unsigned DEPTH = DTQ_DEPTH
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_status,
  input wire logic [15:0] out_head_delay,
  input wire logic [15:0] out_head_tasks,
  input wire logic [5:0]  out_occupancy
);

  // The occupancy field only shows the full count when it fits in six bits.
  localparam logic OCC_EXACT = (DEPTH < 64);

  `DTQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_occupancy))
  `DTQ_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `DTQ_ASSERT_SAME(a_empty_head, out_valid && OCC_EXACT && (out_occupancy == 6'd0), (out_head_delay == 16'd0) && (out_head_tasks == 16'd0))
  `DTQ_ASSERT_SAME(a_insert_nonempty, out_valid && OCC_EXACT && (out_status == STAT_INSERTED), out_occupancy != 6'd0)
  `DTQ_ASSERT_SAME(a_head_positive, out_valid && (out_occupancy != 6'd0), out_head_delay != 16'd0)

endmodule

bind delta_timer_queue_top dtq_checker #(
  .DEPTH(DEPTH)
) u_dtq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_status    (out_status),
  .out_head_delay(out_head_delay),
  .out_head_tasks(out_head_tasks),
  .out_occupancy (out_occupancy)
);

`default_nettype wire
